/* design/assert_macros.svh */
// Assertion macros shared by the drive RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define DMRD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted
`define DMRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/dmrd_pkg.sv */
// Types, constants and speed helpers for the dual motor ramp PWM drive
`timescale 1ns / 1ps

package dmrd_pkg;

    localparam int SPD_W      = 13;
    localparam int MAG_W      = SPD_W + 1;
    localparam int STEP_W     = 12;
    localparam int TMO_W      = 16;
    localparam int FRAC_BITS  = 4;
    localparam int FUNC_W     = 4;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam int AGE_BITS_DEF = 16;
    localparam int PWM_BITS_DEF = 8;

    localparam logic              SMOOTH_RST  = 1'b1;
    localparam logic [STEP_W-1:0] ACCEL_RST   = 12'd80;
    localparam logic [STEP_W-1:0] DECEL_RST   = 12'd160;
    localparam logic [STEP_W-1:0] LIMIT_RST   = 12'd4080;
    localparam logic [STEP_W-1:0] DBAND_RST   = 12'd16;
    localparam logic [TMO_W-1:0]  TIMEOUT_RST = 16'd500;

    typedef enum logic [FUNC_W-1:0] {
        FN_SET_BOTH  = 4'd0,
        FN_SET_LEFT  = 4'd1,
        FN_SET_RIGHT = 4'd2,
        FN_TICK      = 4'd3,
        FN_STOP      = 4'd4,
        FN_HALT      = 4'd5,
        FN_CLR_HALT  = 4'd6,
        FN_ENABLE    = 4'd7,
        FN_DISABLE   = 4'd8,
        FN_RESET     = 4'd9,
        FN_TMO_CHECK = 4'd10
    } func_t;

    typedef enum logic [2:0] {
        REG_SMOOTH  = 3'd0,
        REG_ACCEL   = 3'd1,
        REG_DECEL   = 3'd2,
        REG_LIMIT   = 3'd3,
        REG_DBAND   = 3'd4,
        REG_TIMEOUT = 3'd5
    } reg_idx_t;

    typedef logic signed [SPD_W-1:0] speed_t;
    typedef logic [MAG_W-1:0]        mag_t;

    function automatic mag_t mag_of(input speed_t v);
        logic signed [MAG_W-1:0] w;
        begin
            w = signed'({v[SPD_W-1], v});
            mag_of = w[MAG_W-1] ? mag_t'(-w) : mag_t'(w);
        end
    endfunction

    // clamp to +/-limit, then zero anything inside the deadband
    function automatic speed_t shape(input speed_t v, input logic [STEP_W-1:0] lim,
                                     input logic [STEP_W-1:0] db);
        logic signed [MAG_W-1:0] w;
        logic signed [MAG_W-1:0] l;
        mag_t m;
        begin
            w = signed'({v[SPD_W-1], v});
            l = signed'({2'b00, lim});
            if (w > l)
            begin
                w = l;
            end
            if (w < -l)
            begin
                w = -l;
            end
            m = w[MAG_W-1] ? mag_t'(-w) : mag_t'(w);
            if (m < {2'b00, db})
            begin
                w = '0;
            end
            shape = w[SPD_W-1:0];
        end
    endfunction

    function automatic speed_t ramp(input speed_t now, input speed_t goal,
                                    input logic [STEP_W-1:0] acc,
                                    input logic [STEP_W-1:0] dec);
        logic [STEP_W-1:0]       step;
        logic signed [MAG_W-1:0] diff;
        logic signed [MAG_W-1:0] now_w;
        logic signed [MAG_W-1:0] step_w;
        logic signed [MAG_W-1:0] sum;
        mag_t                    md;
        begin
            step   = (mag_of(goal) > mag_of(now)) ? acc : dec;
            now_w  = signed'({now[SPD_W-1], now});
            step_w = signed'({2'b00, step});
            diff   = signed'({goal[SPD_W-1], goal}) - now_w;
            md     = diff[MAG_W-1] ? mag_t'(-diff) : mag_t'(diff);
            sum    = (goal > now) ? (now_w + step_w) : (now_w - step_w);
            ramp   = (md <= {2'b00, step}) ? goal : sum[SPD_W-1:0];
        end
    endfunction

endpackage

/* design/dmrd_cmd_if.sv */
// Request channel carrying drive commands
`timescale 1ns / 1ps

interface dmrd_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [dmrd_pkg::FUNC_W-1:0]   func;
    logic signed [dmrd_pkg::SPD_W-1:0] left_speed;
    logic signed [dmrd_pkg::SPD_W-1:0] right_speed;

    modport source (output valid, func, left_speed, right_speed, input ready);
    modport sink   (input valid, func, left_speed, right_speed, output ready);
endinterface

/* design/dmrd_res_if.sv */
// Result channel carrying duties, speeds and status
`timescale 1ns / 1ps

interface dmrd_res_if #(
    parameter int PWM_BITS = dmrd_pkg::PWM_BITS_DEF
);
    logic                              valid;
    logic                              ready;
    logic [PWM_BITS-1:0]               pwm_a_fwd;
    logic [PWM_BITS-1:0]               pwm_a_rev;
    logic [PWM_BITS-1:0]               pwm_b_fwd;
    logic [PWM_BITS-1:0]               pwm_b_rev;
    logic signed [dmrd_pkg::SPD_W-1:0] left_now;
    logic signed [dmrd_pkg::SPD_W-1:0] right_now;
    logic signed [dmrd_pkg::SPD_W-1:0] left_goal;
    logic signed [dmrd_pkg::SPD_W-1:0] right_goal;
    logic                              moving;
    logic                              halted;
    logic                              drive_on;
    logic                              timed_out;

    modport source (output valid, pwm_a_fwd, pwm_a_rev, pwm_b_fwd, pwm_b_rev,
                    left_now, right_now, left_goal, right_goal,
                    moving, halted, drive_on, timed_out, input ready);
    modport sink   (input valid, pwm_a_fwd, pwm_a_rev, pwm_b_fwd, pwm_b_rev,
                    left_now, right_now, left_goal, right_goal,
                    moving, halted, drive_on, timed_out, output ready);
endinterface

/* design/dual_motor_ramp_pwm_drive.sv */
// Two-channel slew-limited H-bridge PWM drive, top level
// A request passes the input register, then the state update and result register.
// Throughput: one request per cycle while each result is taken at once;
// the state update is a single clamp/ramp pass.
// The result register lets a new request in while the previous result waits.
// Reset (rst_n low, async): speeds, targets, duties, age and halt cleared,
// drive enabled, configuration registers back to their defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dual_motor_ramp_pwm_drive #(
    parameter int AGE_BITS = dmrd_pkg::AGE_BITS_DEF,
    parameter int PWM_BITS = dmrd_pkg::PWM_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    dmrd_cmd_if.sink                          cmd,
    dmrd_res_if.source                        res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dmrd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [dmrd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [dmrd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int CMP_W = (AGE_BITS > dmrd_pkg::TMO_W) ? AGE_BITS : dmrd_pkg::TMO_W;
    localparam int DSH_W = dmrd_pkg::MAG_W - dmrd_pkg::FRAC_BITS;
    localparam int SAT_W = (PWM_BITS > DSH_W) ? PWM_BITS + 1 : DSH_W + 1;
    localparam logic [SAT_W-1:0] DUTY_TOP = SAT_W'((64'd1 << PWM_BITS) - 64'd1);

    // configuration registers
    logic                             smooth_reg;
    logic [dmrd_pkg::STEP_W-1:0]      accel_reg;
    logic [dmrd_pkg::STEP_W-1:0]      decel_reg;
    logic [dmrd_pkg::STEP_W-1:0]      limit_reg;
    logic [dmrd_pkg::STEP_W-1:0]      dband_reg;
    logic [dmrd_pkg::TMO_W-1:0]       tmo_reg;
    logic                             cfg_wr;
    dmrd_pkg::reg_idx_t               cfg_idx;

    // input stage
    logic                             s1_valid_reg;
    logic [dmrd_pkg::FUNC_W-1:0]      s1_func_reg;
    dmrd_pkg::speed_t                 s1_left_reg;
    dmrd_pkg::speed_t                 s1_right_reg;
    logic                             out_free;
    logic                             s1_fire;

    // drive state
    dmrd_pkg::speed_t                 lp_reg, rp_reg, lt_reg, rt_reg;
    dmrd_pkg::speed_t                 lp_next, rp_next, lt_next, rt_next;
    logic                             en_reg, en_next;
    logic                             halt_reg, halt_next;
    logic [AGE_BITS-1:0]              age_reg, age_next;
    logic [PWM_BITS-1:0]              duty_af_reg, duty_ar_reg, duty_bf_reg, duty_br_reg;
    logic [PWM_BITS-1:0]              duty_af_next, duty_ar_next, duty_bf_next, duty_br_next;
    logic                             refresh;
    logic                             tout;
    logic                             moving;
    dmrd_pkg::speed_t                 set_l, set_r;

    // result register
    logic                             out_valid_reg;
    logic [PWM_BITS-1:0]              o_af_reg, o_ar_reg, o_bf_reg, o_br_reg;
    dmrd_pkg::speed_t                 o_ln_reg, o_rn_reg, o_lg_reg, o_rg_reg;
    logic                             o_mov_reg, o_halt_reg, o_en_reg, o_tout_reg;

    function automatic logic [PWM_BITS-1:0] duty_of(input dmrd_pkg::speed_t v);
        logic [SAT_W-1:0] d;
        begin
            d = SAT_W'(dmrd_pkg::mag_of(v) >> dmrd_pkg::FRAC_BITS);
            duty_of = (d > DUTY_TOP) ? PWM_BITS'(DUTY_TOP) : PWM_BITS'(d);
        end
    endfunction

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = dmrd_pkg::reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_reg <= dmrd_pkg::SMOOTH_RST;
            accel_reg  <= dmrd_pkg::ACCEL_RST;
            decel_reg  <= dmrd_pkg::DECEL_RST;
            limit_reg  <= dmrd_pkg::LIMIT_RST;
            dband_reg  <= dmrd_pkg::DBAND_RST;
            tmo_reg    <= dmrd_pkg::TIMEOUT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                dmrd_pkg::REG_SMOOTH:  smooth_reg <= pwdata[0];
                dmrd_pkg::REG_ACCEL:   accel_reg  <= pwdata[dmrd_pkg::STEP_W-1:0];
                dmrd_pkg::REG_DECEL:   decel_reg  <= pwdata[dmrd_pkg::STEP_W-1:0];
                dmrd_pkg::REG_LIMIT:   limit_reg  <= pwdata[dmrd_pkg::STEP_W-1:0];
                dmrd_pkg::REG_DBAND:   dband_reg  <= pwdata[dmrd_pkg::STEP_W-1:0];
                dmrd_pkg::REG_TIMEOUT: tmo_reg    <= pwdata[dmrd_pkg::TMO_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            dmrd_pkg::REG_SMOOTH:  prdata = dmrd_pkg::APB_DATA_W'(smooth_reg);
            dmrd_pkg::REG_ACCEL:   prdata = dmrd_pkg::APB_DATA_W'(accel_reg);
            dmrd_pkg::REG_DECEL:   prdata = dmrd_pkg::APB_DATA_W'(decel_reg);
            dmrd_pkg::REG_LIMIT:   prdata = dmrd_pkg::APB_DATA_W'(limit_reg);
            dmrd_pkg::REG_DBAND:   prdata = dmrd_pkg::APB_DATA_W'(dband_reg);
            dmrd_pkg::REG_TIMEOUT: prdata = dmrd_pkg::APB_DATA_W'(tmo_reg);
            default:               prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    assign out_free  = !out_valid_reg || res.ready;
    assign s1_fire   = s1_valid_reg && out_free;
    assign cmd.ready = !s1_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            s1_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            s1_func_reg  <= cmd.func;
            s1_left_reg  <= cmd.left_speed;
            s1_right_reg <= cmd.right_speed;
        end
    end

    // ---------------- command decode and state update ----------------
    // set left re-shapes the held right target, and the other way round
    assign set_l = (dmrd_pkg::func_t'(s1_func_reg) == dmrd_pkg::FN_SET_RIGHT)
                   ? lt_reg : s1_left_reg;
    assign set_r = (dmrd_pkg::func_t'(s1_func_reg) == dmrd_pkg::FN_SET_LEFT)
                   ? rt_reg : s1_right_reg;

    always_comb
    begin
        lp_next   = lp_reg;
        rp_next   = rp_reg;
        lt_next   = lt_reg;
        rt_next   = rt_reg;
        en_next   = en_reg;
        halt_next = halt_reg;
        age_next  = age_reg;
        refresh   = 1'b0;
        tout      = 1'b0;

        case (dmrd_pkg::func_t'(s1_func_reg)) inside
            dmrd_pkg::FN_SET_BOTH, dmrd_pkg::FN_SET_LEFT, dmrd_pkg::FN_SET_RIGHT:
            begin
                if (en_reg && !halt_reg)
                begin
                    lt_next  = dmrd_pkg::shape(set_l, limit_reg, dband_reg);
                    rt_next  = dmrd_pkg::shape(set_r, limit_reg, dband_reg);
                    age_next = '0;
                    if (!smooth_reg)
                    begin
                        lp_next = lt_next;
                        rp_next = rt_next;
                        refresh = 1'b1;
                    end
                end
            end
            dmrd_pkg::FN_TICK:
            begin
                if (age_reg != '1)
                begin
                    age_next = age_reg + 1'b1;
                end
                if (smooth_reg)
                begin
                    lp_next = dmrd_pkg::ramp(lp_reg, lt_reg, accel_reg, decel_reg);
                    rp_next = dmrd_pkg::ramp(rp_reg, rt_reg, accel_reg, decel_reg);
                    refresh = 1'b1;
                end
            end
            dmrd_pkg::FN_HALT:
            begin
                halt_next = 1'b1;
                lp_next   = '0;
                rp_next   = '0;
                lt_next   = '0;
                rt_next   = '0;
                refresh   = 1'b1;
            end
            dmrd_pkg::FN_CLR_HALT:
            begin
                halt_next = 1'b0;
            end
            dmrd_pkg::FN_ENABLE:
            begin
                if (!halt_reg)
                begin
                    en_next = 1'b1;
                end
            end
            dmrd_pkg::FN_STOP, dmrd_pkg::FN_DISABLE, dmrd_pkg::FN_RESET,
            dmrd_pkg::FN_TMO_CHECK:
            begin
                // all of these stop, the timeout check only once the age passes the limit
                if (dmrd_pkg::func_t'(s1_func_reg) != dmrd_pkg::FN_TMO_CHECK ||
                    CMP_W'(age_reg) > CMP_W'(tmo_reg))
                begin
                    lt_next = '0;
                    rt_next = '0;
                    if (!smooth_reg || halt_reg)
                    begin
                        lp_next = '0;
                        rp_next = '0;
                        refresh = 1'b1;
                    end
                end
                if (dmrd_pkg::func_t'(s1_func_reg) == dmrd_pkg::FN_TMO_CHECK)
                begin
                    tout = CMP_W'(age_reg) > CMP_W'(tmo_reg);
                end
                if (dmrd_pkg::func_t'(s1_func_reg) == dmrd_pkg::FN_DISABLE)
                begin
                    en_next = 1'b0;
                end
                if (dmrd_pkg::func_t'(s1_func_reg) == dmrd_pkg::FN_RESET)
                begin
                    // duties stay as they were unless the stop refreshed them
                    lp_next   = '0;
                    rp_next   = '0;
                    halt_next = 1'b0;
                    age_next  = '0;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        duty_af_next = duty_af_reg;
        duty_ar_next = duty_ar_reg;
        duty_bf_next = duty_bf_reg;
        duty_br_next = duty_br_reg;
        if (refresh)
        begin
            duty_af_next = lp_next[dmrd_pkg::SPD_W-1] ? '0 : duty_of(lp_next);
            duty_ar_next = lp_next[dmrd_pkg::SPD_W-1] ? duty_of(lp_next) : '0;
            duty_bf_next = rp_next[dmrd_pkg::SPD_W-1] ? '0 : duty_of(rp_next);
            duty_br_next = rp_next[dmrd_pkg::SPD_W-1] ? duty_of(rp_next) : '0;
        end
    end

    assign moving = (dmrd_pkg::mag_of(lp_next) > {2'b00, dband_reg}) ||
                    (dmrd_pkg::mag_of(rp_next) > {2'b00, dband_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_reg      <= '0;
            rp_reg      <= '0;
            lt_reg      <= '0;
            rt_reg      <= '0;
            en_reg      <= 1'b1;
            halt_reg    <= 1'b0;
            age_reg     <= '0;
            duty_af_reg <= '0;
            duty_ar_reg <= '0;
            duty_bf_reg <= '0;
            duty_br_reg <= '0;
        end
        else if (s1_fire)
        begin
            lp_reg      <= lp_next;
            rp_reg      <= rp_next;
            lt_reg      <= lt_next;
            rt_reg      <= rt_next;
            en_reg      <= en_next;
            halt_reg    <= halt_next;
            age_reg     <= age_next;
            duty_af_reg <= duty_af_next;
            duty_ar_reg <= duty_ar_next;
            duty_bf_reg <= duty_bf_next;
            duty_br_reg <= duty_br_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            o_af_reg   <= duty_af_next;
            o_ar_reg   <= duty_ar_next;
            o_bf_reg   <= duty_bf_next;
            o_br_reg   <= duty_br_next;
            o_ln_reg   <= lp_next;
            o_rn_reg   <= rp_next;
            o_lg_reg   <= lt_next;
            o_rg_reg   <= rt_next;
            o_mov_reg  <= moving;
            o_halt_reg <= halt_next;
            o_en_reg   <= en_next;
            o_tout_reg <= tout;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.pwm_a_fwd  = o_af_reg;
    assign res.pwm_a_rev  = o_ar_reg;
    assign res.pwm_b_fwd  = o_bf_reg;
    assign res.pwm_b_rev  = o_br_reg;
    assign res.left_now   = o_ln_reg;
    assign res.right_now  = o_rn_reg;
    assign res.left_goal  = o_lg_reg;
    assign res.right_goal = o_rg_reg;
    assign res.moving     = o_mov_reg;
    assign res.halted     = o_halt_reg;
    assign res.drive_on   = o_en_reg;
    assign res.timed_out  = o_tout_reg;

    // ---------------- assertions ----------------
    `DMRD_ASSERT_NOW(a_halt_zero, clk, rst_n, halt_reg, lp_reg == '0 && rp_reg == '0 && lt_reg == '0 && rt_reg == '0, "halted with nonzero speed or target")
    `DMRD_ASSERT_NOW(a_tout_stops, clk, rst_n, out_valid_reg && o_tout_reg, o_lg_reg == '0 && o_rg_reg == '0, "timeout result with nonzero target")
    `DMRD_ASSERT_NEXT(a_fire_result, clk, rst_n, s1_fire, out_valid_reg, "processed request left no result")

endmodule
